/* hw/rtl/rolling_voxel_log_odds_map_defines.svh */
// Assertion macros used by the voxel map top level.
`ifndef ROLLING_VOXEL_LOG_ODDS_MAP_DEFINES_SVH
`define ROLLING_VOXEL_LOG_ODDS_MAP_DEFINES_SVH

`ifndef SYNTHESIS
`define RVL_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("voxel map check failed");
`define RVL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("voxel map check failed");
`else
`define RVL_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define RVL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/rvl_pkg.sv */
`default_nettype none
package rvl_pkg;

    localparam int SIZE_X    = 64;
    localparam int SIZE_Y    = 64;
    localparam int SIZE_Z    = 16;
    localparam int NUM_CELLS = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int ADDR_W    = $clog2(NUM_CELLS);
    localparam int XW        = $clog2(SIZE_X);
    localparam int YW        = $clog2(SIZE_Y);
    localparam int ZW        = $clog2(SIZE_Z);
    localparam int RW        = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
    localparam int QDEPTH    = 2;
    localparam int QPW       = $clog2(QDEPTH);
    localparam int WORD_W    = 48;

    typedef enum logic [1:0] {
        ACT_HIT   = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_SHIFT = 2'd2,
        ACT_READ  = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_HIT,
        OP_FREE,
        OP_CLEAR,
        OP_SLIDE
    } op_t;

    typedef enum logic [1:0] {
        SR_NONE  = 2'd0,
        SR_SMALL = 2'd1,
        SR_CLEAR = 2'd2,
        SR_SLID  = 2'd3
    } shres_t;

    typedef enum logic [2:0] {
        CFG_HIT_WEIGHT  = 3'd0,
        CFG_FREE_WEIGHT = 3'd1,
        CFG_LO_MAX      = 3'd2,
        CFG_LO_MIN      = 3'd3,
        CFG_MIN_SHIFT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SW_FULL,
        SW_AX_X,
        SW_AX_Y,
        SW_AX_Z
    } sweep_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_UPD_WR,
        ST_SWEEP,
        ST_AXIS,
        ST_RD_ADDR,
        ST_RD_DATA
    } bk_state_t;

    typedef struct packed {
        logic        [14:0] hit_weight;
        logic signed [15:0] free_weight;
        logic signed [15:0] lo_max;
        logic signed [15:0] lo_min;
        logic        [6:0]  shift_floor;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        shres_t             sres;
        logic               idx_ok;
        logic        [15:0] idx;
        logic        [7:0]  count;
        logic        [31:0] stamp;
        logic               neg_x;
        logic               neg_y;
        logic               neg_z;
        logic        [7:0]  ax;
        logic        [7:0]  ay;
        logic        [7:0]  az;
    } item_t;

    typedef struct packed {
        logic init_busy;
        logic res_load;
    } bk_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/rvl_front.sv */
`default_nettype none
module rvl_front import rvl_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               init_busy,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [1:0]  s_action,
    input  wire logic        [15:0] s_cell_index,
    input  wire logic        [7:0]  s_hit_count,
    input  wire logic        [31:0] s_stamp,
    input  wire logic signed [7:0]  s_shift_x,
    input  wire logic signed [7:0]  s_shift_y,
    input  wire logic signed [7:0]  s_shift_z,
    output logic                    q_push,
    output item_t                   q_item,
    input  wire logic               q_ready
);

    logic  fv_reg, fv_next;
    item_t item_reg;
    item_t cls;
    logic  accept;
    logic  tiny, full;

    // Magnitude of a signed 8-bit shift; -128 becomes 128.
    function automatic logic [7:0] mag8(input logic signed [7:0] s);
        logic [8:0] w;
        w = s[7] ? (9'd0 - {s[7], s}) : {1'b0, s};
        return w[7:0];
    endfunction

    always_comb begin
        cls        = '0;
        cls.idx    = s_cell_index;
        cls.count  = s_hit_count;
        cls.stamp  = s_stamp;
        cls.idx_ok = (int'(s_cell_index) < NUM_CELLS);
        cls.neg_x  = s_shift_x[7];
        cls.neg_y  = s_shift_y[7];
        cls.neg_z  = s_shift_z[7];
        cls.ax     = mag8(s_shift_x);
        cls.ay     = mag8(s_shift_y);
        cls.az     = mag8(s_shift_z);
        tiny = (cls.ax < {1'b0, cfg.shift_floor}) && (cls.ay < {1'b0, cfg.shift_floor})
               && (cls.az < {1'b0, cfg.shift_floor});
        full  = (int'(cls.ax) >= SIZE_X) || (int'(cls.ay) >= SIZE_Y)
                || (int'(cls.az) >= SIZE_Z);
        cls.op   = OP_READ;
        cls.sres = SR_NONE;
        case (act_t'(s_action))
            ACT_HIT: begin
                if (cls.idx_ok && s_hit_count != 8'd0) cls.op = OP_HIT;
            end
            ACT_FREE: begin
                if (cls.idx_ok && s_hit_count != 8'd0) cls.op = OP_FREE;
            end
            ACT_SHIFT: begin
                if (tiny) begin
                    cls.sres = SR_SMALL;
                end else if (full) begin
                    cls.op   = OP_CLEAR;
                    cls.sres = SR_CLEAR;
                end else begin
                    cls.op   = OP_SLIDE;
                    cls.sres = SR_SLID;
                end
            end
            default: cls.op = OP_READ;
        endcase
    end

    assign s_ready = (!fv_reg || q_ready) && !init_busy;
    assign accept  = s_valid && s_ready;
    assign q_push  = fv_reg && q_ready;
    assign q_item  = item_reg;

    always_comb begin
        fv_next = fv_reg;
        if (accept) fv_next = 1'b1;
        else if (q_push) fv_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
        if (accept) item_reg <= cls;
    end

endmodule
`default_nettype wire

/* hw/rtl/rvl_queue.sv */
`default_nettype none
module rvl_queue import rvl_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       push_ready,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       pop_valid
);

    item_t              slot_reg [QDEPTH];
    logic [QPW-1:0]     wp_reg, wp_next, rp_reg, rp_next;
    logic [QPW:0]       cnt_reg, cnt_next;

    assign push_ready = (int'(cnt_reg) != QDEPTH);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = slot_reg[rp_reg];

    function automatic logic [QPW-1:0] wrap_inc(input logic [QPW-1:0] p);
        return (int'(p) == QDEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wp_next  = push ? wrap_inc(wp_reg) : wp_reg;
        rp_next  = pop ? wrap_inc(rp_reg) : rp_reg;
        cnt_next = cnt_reg + (QPW+1)'(push) - (QPW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) slot_reg[wp_reg] <= push_item;
    end

endmodule
`default_nettype wire

/* hw/rtl/rvl_back.sv */
`default_nettype none
module rvl_back import rvl_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               q_valid,
    input  wire item_t              q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_cell_log_odds,
    output logic        [31:0]      m_cell_stamp,
    output logic        [5:0]       m_ring_x,
    output logic        [5:0]       m_ring_y,
    output logic        [3:0]       m_ring_z,
    output logic        [1:0]       m_shift_result,
    output bk_stat_t                stat
);

    bk_state_t         state_reg, state_next;
    sweep_t            sweep_reg, sweep_next;
    item_t             item_reg, item_next;
    logic [XW-1:0]     cx_reg, cx_next, offx_reg, offx_next;
    logic [YW-1:0]     cy_reg, cy_next, offy_reg, offy_next;
    logic [ZW-1:0]     cz_reg, cz_next, offz_reg, offz_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic signed [24:0] prod_reg, prod_next;
    logic              mv_reg, mv_next;
    logic signed [15:0] rlo_reg, rlo_next;
    logic [31:0]       rst_reg, rst_next;
    logic [5:0]        rx_reg, rx_next, ry_reg, ry_next;
    logic [3:0]        rz_reg, rz_next;
    logic [1:0]        rsr_reg, rsr_next;

    logic [WORD_W-1:0] mem [NUM_CELLS];
    logic [WORD_W-1:0] rd_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              res_load;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[mem_raddr];
    end

    always_comb begin
        logic              zl, yl, xl, slice_done, sweep_end, start, ax_neg, ax_zero;
        logic [7:0]        ab;
        logic signed [25:0] v;
        logic signed [24:0] wt;
        int                off_i, dim_i, st_i, fix_i, noff_i;

        state_next = state_reg;
        sweep_next = sweep_reg;
        item_next  = item_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        offx_next  = offx_reg;
        offy_next  = offy_reg;
        offz_next  = offz_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        mv_next    = mv_reg;
        rlo_next   = rlo_reg;
        rst_next   = rst_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rz_next    = rz_reg;
        rsr_next   = rsr_reg;
        q_pop      = 1'b0;
        res_load   = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = '0;
        mem_waddr  = ADDR_W'((int'(cx_reg) * SIZE_Y + int'(cy_reg)) * SIZE_Z + int'(cz_reg));
        mem_raddr  = ADDR_W'(item_reg.idx);
        v          = '0;
        wt         = '0;
        slice_done = 1'b0;
        sweep_end  = 1'b0;
        start      = q_valid && (!mv_reg || m_ready);

        if (mv_reg && m_ready) mv_next = 1'b0;

        zl = (int'(cz_reg) == SIZE_Z - 1);
        yl = (int'(cy_reg) == SIZE_Y - 1);
        xl = (int'(cx_reg) == SIZE_X - 1);

        // Per-axis setup values for ST_AXIS
        case (sweep_reg)
            SW_AX_Y: begin
                ax_neg = item_reg.neg_y; ab = item_reg.ay;
                off_i = int'(offy_reg); dim_i = SIZE_Y;
            end
            SW_AX_Z: begin
                ax_neg = item_reg.neg_z; ab = item_reg.az;
                off_i = int'(offz_reg); dim_i = SIZE_Z;
            end
            default: begin
                ax_neg = item_reg.neg_x; ab = item_reg.ax;
                off_i = int'(offx_reg); dim_i = SIZE_X;
            end
        endcase
        ax_zero = (ab == 8'd0);
        st_i    = int'(ab);
        if (ax_neg) begin
            fix_i  = (off_i == 0) ? dim_i - 1 : off_i - 1;
            noff_i = (off_i >= st_i) ? off_i - st_i : off_i + dim_i - st_i;
        end else begin
            fix_i  = off_i;
            noff_i = (off_i + st_i >= dim_i) ? off_i + st_i - dim_i : off_i + st_i;
        end

        case (state_reg)
            ST_INIT, ST_SWEEP: begin
                mem_we = 1'b1;
                case (sweep_reg)
                    SW_FULL: begin
                        cz_next = zl ? '0 : cz_reg + 1'b1;
                        if (zl) begin
                            cy_next = yl ? '0 : cy_reg + 1'b1;
                            if (yl) begin
                                cx_next = xl ? '0 : cx_reg + 1'b1;
                                sweep_end = xl;
                            end
                        end
                    end
                    SW_AX_X: begin
                        cz_next = zl ? '0 : cz_reg + 1'b1;
                        if (zl) begin
                            cy_next = yl ? '0 : cy_reg + 1'b1;
                            slice_done = yl;
                        end
                    end
                    SW_AX_Y: begin
                        cz_next = zl ? '0 : cz_reg + 1'b1;
                        if (zl) begin
                            cx_next = xl ? '0 : cx_reg + 1'b1;
                            slice_done = xl;
                        end
                    end
                    default: begin
                        cy_next = yl ? '0 : cy_reg + 1'b1;
                        if (yl) begin
                            cx_next = xl ? '0 : cx_reg + 1'b1;
                            slice_done = xl;
                        end
                    end
                endcase
                if (sweep_end) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RD_ADDR;
                end
                if (slice_done) begin
                    if (rem_reg == RW'(1)) begin
                        // axis finished: move on to the next one, or read the addressed voxel after Z
                        if (sweep_reg == SW_AX_Z) begin
                            state_next = ST_RD_ADDR;
                        end else begin
                            sweep_next = (sweep_reg == SW_AX_X) ? SW_AX_Y : SW_AX_Z;
                            state_next = ST_AXIS;
                        end
                    end else begin
                        rem_next = rem_reg - 1'b1;
                        case (sweep_reg)
                            SW_AX_X: begin
                                if (neg_reg) cx_next = (cx_reg == '0) ? XW'(SIZE_X - 1)
                                                                      : cx_reg - 1'b1;
                                else cx_next = xl ? '0 : cx_reg + 1'b1;
                            end
                            SW_AX_Y: begin
                                if (neg_reg) cy_next = (cy_reg == '0) ? YW'(SIZE_Y - 1)
                                                                      : cy_reg - 1'b1;
                                else cy_next = yl ? '0 : cy_reg + 1'b1;
                            end
                            default: begin
                                if (neg_reg) cz_next = (cz_reg == '0) ? ZW'(SIZE_Z - 1)
                                                                      : cz_reg - 1'b1;
                                else cz_next = zl ? '0 : cz_reg + 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_IDLE: begin
                mem_raddr = ADDR_W'(q_item.idx);
                // weight times count, ready for the update cycle
                if (q_item.op == OP_HIT)
                    wt = 25'(signed'({1'b0, cfg.hit_weight}));
                else
                    wt = 25'(cfg.free_weight);
                prod_next = wt * 25'(signed'({1'b0, q_item.count}));
                if (start) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    case (q_item.op)
                        OP_HIT, OP_FREE: state_next = ST_UPD_WR;
                        OP_CLEAR: begin
                            sweep_next = SW_FULL;
                            cx_next = '0; cy_next = '0; cz_next = '0;
                            state_next = ST_SWEEP;
                        end
                        OP_SLIDE: begin
                            sweep_next = SW_AX_X;
                            state_next = ST_AXIS;
                        end
                        default: state_next = ST_RD_DATA;
                    endcase
                end
            end
            ST_AXIS: begin
                if (ax_zero) begin
                    if (sweep_reg == SW_AX_Z) state_next = ST_RD_ADDR;
                    else sweep_next = (sweep_reg == SW_AX_X) ? SW_AX_Y : SW_AX_Z;
                end else begin
                    rem_next   = RW'(st_i);
                    neg_next   = ax_neg;
                    state_next = ST_SWEEP;
                    cx_next = '0; cy_next = '0; cz_next = '0;
                    case (sweep_reg)
                        SW_AX_Y: begin
                            cy_next = YW'(fix_i); offy_next = YW'(noff_i);
                        end
                        SW_AX_Z: begin
                            cz_next = ZW'(fix_i); offz_next = ZW'(noff_i);
                        end
                        default: begin
                            cx_next = XW'(fix_i); offx_next = XW'(noff_i);
                        end
                    endcase
                end
            end
            ST_UPD_WR: begin
                v = 26'(signed'(rd_reg[47:32])) + 26'(prod_reg);
                if (item_reg.op == OP_HIT) begin
                    if (v > 26'(cfg.lo_max)) v = 26'(cfg.lo_max);
                end else begin
                    if (v < 26'(cfg.lo_min)) v = 26'(cfg.lo_min);
                    if (v > 26'sd32767) v = 26'sd32767;
                end
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(item_reg.idx);
                mem_wdata = {v[15:0], item_reg.stamp};
                res_load  = 1'b1;
                rlo_next  = v[15:0];
                rst_next  = item_reg.stamp;
                state_next = ST_IDLE;
            end
            ST_RD_ADDR: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                res_load   = 1'b1;
                rlo_next   = item_reg.idx_ok ? signed'(rd_reg[47:32]) : 16'sd0;
                rst_next   = item_reg.idx_ok ? rd_reg[31:0] : 32'd0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (res_load) begin
            mv_next  = 1'b1;
            rx_next  = 6'(offx_reg);
            ry_next  = 6'(offy_reg);
            rz_next  = 4'(offz_reg);
            rsr_next = item_reg.sres;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            sweep_reg <= SW_FULL;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            offx_reg  <= '0;
            offy_reg  <= '0;
            offz_reg  <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            cz_reg    <= cz_next;
            offx_reg  <= offx_next;
            offy_reg  <= offy_next;
            offz_reg  <= offz_next;
            rem_reg   <= rem_next;
            neg_reg   <= neg_next;
            mv_reg    <= mv_next;
        end
        item_reg <= item_next;
        prod_reg <= prod_next;
        rlo_reg  <= rlo_next;
        rst_reg  <= rst_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rz_reg   <= rz_next;
        rsr_reg  <= rsr_next;
    end

    assign m_valid         = mv_reg;
    assign m_cell_log_odds = rlo_reg;
    assign m_cell_stamp    = rst_reg;
    assign m_ring_x        = rx_reg;
    assign m_ring_y        = ry_reg;
    assign m_ring_z        = rz_reg;
    assign m_shift_result  = rsr_reg;
    assign stat.init_busy  = (state_reg == ST_INIT);
    assign stat.res_load   = res_load;

endmodule
`default_nettype wire

/* hw/rtl/rolling_voxel_log_odds_map.sv */
// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    action, cell_index, hit_count, stamp, shift_x/y/z
// m_       out        m_valid / m_ready    cell_log_odds, cell_stamp, ring_x/y/z, shift_result
// cfg_     in         cfg_valid / cfg_ready  cfg_index (register number), cfg_data
//
// Hit, free and read items read the voxel RAM in ST_IDLE, then update it (ST_UPD_WR)
// or capture the word (ST_RD_DATA) in the back end; the RAM has a single read port.
// A slide starts in ST_IDLE, runs an ST_AXIS setup per axis and one RAM write per voxel
// in the vacated slices, then reads the addressed voxel in ST_RD_ADDR and ST_RD_DATA;
// a full clear writes all NUM_CELLS voxels (65536 at 64x64x16) before that readback.
// After reset a clearing pass writes all NUM_CELLS voxels of the RAM; no transfer is
// taken on s_ during it, configuration writes are.
// A two-entry queue between front and back lets the front keep taking transfers
// while the back works or the result register waits on m_ready.
`default_nettype none
`include "rolling_voxel_log_odds_map_defines.svh"
module rolling_voxel_log_odds_map import rvl_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [1:0]  s_action,
    input  wire logic        [15:0] s_cell_index,
    input  wire logic        [7:0]  s_hit_count,
    input  wire logic        [31:0] s_stamp,
    input  wire logic signed [7:0]  s_shift_x,
    input  wire logic signed [7:0]  s_shift_y,
    input  wire logic signed [7:0]  s_shift_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_cell_log_odds,
    output logic        [31:0]      m_cell_stamp,
    output logic        [5:0]       m_ring_x,
    output logic        [5:0]       m_ring_y,
    output logic        [3:0]       m_ring_z,
    output logic        [1:0]       m_shift_result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [15:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    bk_stat_t stat;
    logic     q_push, q_ready, q_pop, q_valid;
    item_t    push_item, pop_item;

    // Register file: always ready, writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_HIT_WEIGHT:  cfg_next.hit_weight  = cfg_data[14:0];
                CFG_FREE_WEIGHT: cfg_next.free_weight = signed'(cfg_data);
                CFG_LO_MAX:      cfg_next.lo_max      = signed'(cfg_data);
                CFG_LO_MIN:      cfg_next.lo_min      = signed'(cfg_data);
                CFG_MIN_SHIFT:   cfg_next.shift_floor = cfg_data[6:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hit_weight  <= 15'd217;
            cfg_reg.free_weight <= -16'sd103;
            cfg_reg.lo_max      <= 16'sd896;
            cfg_reg.lo_min      <= -16'sd512;
            cfg_reg.shift_floor <= 7'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify the transfer and hold it for the queue.
    rvl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .init_busy    (stat.init_busy),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_cell_index (s_cell_index),
        .s_hit_count  (s_hit_count),
        .s_stamp      (s_stamp),
        .s_shift_x    (s_shift_x),
        .s_shift_y    (s_shift_y),
        .s_shift_z    (s_shift_z),
        .q_push       (q_push),
        .q_item       (push_item),
        .q_ready      (q_ready)
    );

    rvl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_item   (pop_item),
        .pop_valid  (q_valid)
    );

    // Back: voxel RAM, sweeps and the result register.
    rvl_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_log_odds (m_cell_log_odds),
        .m_cell_stamp    (m_cell_stamp),
        .m_ring_x        (m_ring_x),
        .m_ring_y        (m_ring_y),
        .m_ring_z        (m_ring_z),
        .m_shift_result  (m_shift_result),
        .stat            (stat)
    );

    // A new result only lands in a free output register.
    `RVL_ASSERT_IMPLIES(a_res_slot_free, aclk, aresetn, stat.res_load, !m_valid || m_ready)
    // A loaded result shows up on the port in the next cycle.
    `RVL_ASSERT_NEXT(a_res_shows, aclk, aresetn, stat.res_load, m_valid)
    // After a full clear the addressed voxel reads back empty.
    `RVL_ASSERT_IMPLIES(a_clear_empty, aclk, aresetn, m_valid && m_shift_result == SR_CLEAR, m_cell_log_odds == 16'sd0 && m_cell_stamp == 32'd0)
    // No transfer is taken while the reset clearing pass runs.
    `RVL_ASSERT_IMPLIES(a_init_blocks, aclk, aresetn, stat.init_busy, !s_ready)

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import rvl_pkg::*;

    localparam int CELLS      = 65536;
    localparam int WDOG_LIMIT = 250000;
    localparam int PHASE_LEN  = 90;
    localparam int N_PHASES   = 5;

    typedef struct {
        act_t               act;
        logic        [15:0] idx;
        logic        [7:0]  cnt;
        logic        [31:0] stmp;
        logic signed [7:0]  sx;
        logic signed [7:0]  sy;
        logic signed [7:0]  sz;
    } voxel_op_t;

    typedef struct {
        logic signed [15:0] lo;
        logic        [31:0] st;
        logic        [5:0]  rx;
        logic        [5:0]  ry;
        logic        [3:0]  rz;
        logic        [1:0]  sr;
    } voxel_res_t;

    // Scoreboard: keeps its own copy of the voxel map and the registers and
    // queues the result each accepted transfer should produce.
    class voxel_map_board;
        logic signed [15:0] odds[CELLS];
        logic        [31:0] stamps[CELLS];
        logic        [5:0]  ofs_x, ofs_y;
        logic        [3:0]  ofs_z;
        logic        [14:0] hit_w;
        logic signed [15:0] free_w, lo_max, lo_min;
        logic        [6:0]  min_sh;
        voxel_res_t         awaited[$];
        int                 errors, n_in, n_out, n_clear, n_slide, n_small;

        function new();
            foreach (odds[i]) begin
                odds[i]   = '0;
                stamps[i] = '0;
            end
            ofs_x = '0; ofs_y = '0; ofs_z = '0;
            hit_w = 15'd217; free_w = -16'sd103; lo_max = 16'sd896; lo_min = -16'sd512;
            min_sh = 7'd1;
        endfunction

        function void write_reg(cfg_idx_t ri, logic [15:0] d);
            case (ri)
                CFG_HIT_WEIGHT:  hit_w  = d[14:0];
                CFG_FREE_WEIGHT: free_w = d;
                CFG_LO_MAX:      lo_max = d;
                CFG_LO_MIN:      lo_min = d;
                CFG_MIN_SHIFT:   min_sh = d[6:0];
                default: ;
            endcase
        endfunction

        function void wipe_slice(int axis, int sl);
            int c;
            if (axis == 0) begin
                for (int a = 0; a < SIZE_Y; a++)
                    for (int b = 0; b < SIZE_Z; b++) begin
                        c = (sl * SIZE_Y + a) * SIZE_Z + b;
                        odds[c] = '0; stamps[c] = '0;
                    end
            end else if (axis == 1) begin
                for (int a = 0; a < SIZE_X; a++)
                    for (int b = 0; b < SIZE_Z; b++) begin
                        c = (a * SIZE_Y + sl) * SIZE_Z + b;
                        odds[c] = '0; stamps[c] = '0;
                    end
            end else begin
                for (int a = 0; a < SIZE_X; a++)
                    for (int b = 0; b < SIZE_Y; b++) begin
                        c = (a * SIZE_Y + b) * SIZE_Z + sl;
                        odds[c] = '0; stamps[c] = '0;
                    end
            end
        endfunction

        // Clear the vacated slices of one axis, then advance its ring offset.
        function int slide_axis(int axis, int sh, int dim, int ofs);
            int steps;
            if (sh == 0) return ofs;
            steps = (sh < 0) ? -sh : sh;
            for (int k = 0; k < steps; k++)
                wipe_slice(axis, (sh > 0) ? (ofs + k) % dim : (ofs + dim - 1 - k) % dim);
            return (sh > 0) ? (ofs + steps) % dim : (ofs + dim - steps) % dim;
        endfunction

        function void note_input(voxel_op_t op);
            longint     v;
            int         ax, ay, az;
            voxel_res_t r;
            r.sr = SR_NONE;
            n_in++;
            if ((op.act == ACT_HIT || op.act == ACT_FREE) && op.cnt != 0) begin
                v = odds[op.idx];
                if (op.act == ACT_HIT) begin
                    v += longint'(hit_w) * op.cnt;
                    if (v > lo_max) v = lo_max;
                end else begin
                    v += longint'(free_w) * op.cnt;
                    if (v < lo_min) v = lo_min;
                    if (v > 32767) v = 32767;
                end
                odds[op.idx]   = v[15:0];
                stamps[op.idx] = op.stmp;
            end else if (op.act == ACT_SHIFT) begin
                ax = (op.sx < 0) ? -int'(op.sx) : int'(op.sx);
                ay = (op.sy < 0) ? -int'(op.sy) : int'(op.sy);
                az = (op.sz < 0) ? -int'(op.sz) : int'(op.sz);
                if (ax < min_sh && ay < min_sh && az < min_sh) begin
                    r.sr = SR_SMALL;
                    n_small++;
                end else if (ax >= SIZE_X || ay >= SIZE_Y || az >= SIZE_Z) begin
                    foreach (odds[i]) begin
                        odds[i] = '0; stamps[i] = '0;
                    end
                    r.sr = SR_CLEAR;
                    n_clear++;
                end else begin
                    ofs_x = 6'(slide_axis(0, op.sx, SIZE_X, ofs_x));
                    ofs_y = 6'(slide_axis(1, op.sy, SIZE_Y, ofs_y));
                    ofs_z = 4'(slide_axis(2, op.sz, SIZE_Z, ofs_z));
                    r.sr = SR_SLID;
                    n_slide++;
                end
            end
            r.lo = odds[op.idx];
            r.st = stamps[op.idx];
            r.rx = ofs_x; r.ry = ofs_y; r.rz = ofs_z;
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(voxel_res_t got);
            voxel_res_t w;
            n_out++;
            if (awaited.size() == 0) begin
                $error("result transfer with nothing outstanding");
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (got.lo !== w.lo) begin
                $error("cell_log_odds exp %0d got %0d", w.lo, got.lo); errors++;
            end
            if (got.st !== w.st) begin
                $error("cell_stamp exp %0h got %0h", w.st, got.st); errors++;
            end
            if (got.rx !== w.rx) begin
                $error("ring_x exp %0d got %0d", w.rx, got.rx); errors++;
            end
            if (got.ry !== w.ry) begin
                $error("ring_y exp %0d got %0d", w.ry, got.ry); errors++;
            end
            if (got.rz !== w.rz) begin
                $error("ring_z exp %0d got %0d", w.rz, got.rz); errors++;
            end
            if (got.sr !== w.sr) begin
                $error("shift_result exp %0d got %0d", w.sr, got.sr); errors++;
            end
        endfunction
    endclass

    logic               aclk, aresetn;
    logic               s_valid, s_ready;
    logic        [1:0]  s_action;
    logic        [15:0] s_cell_index;
    logic        [7:0]  s_hit_count;
    logic        [31:0] s_stamp;
    logic signed [7:0]  s_shift_x, s_shift_y, s_shift_z;
    logic               m_valid, m_ready;
    logic signed [15:0] m_cell_log_odds;
    logic        [31:0] m_cell_stamp;
    logic        [5:0]  m_ring_x, m_ring_y;
    logic        [3:0]  m_ring_z;
    logic        [1:0]  m_shift_result;
    logic               cfg_valid, cfg_ready;
    logic        [2:0]  cfg_index;
    logic        [15:0] cfg_data;

    voxel_map_board sb = new();
    logic [15:0]    hot_cells[12];
    int             clears_left = 3;
    int             n_cfg;
    bit             no_idle;
    int             quiet_cycles;

    rolling_voxel_log_odds_map dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_action, .s_cell_index, .s_hit_count, .s_stamp,
        .s_shift_x, .s_shift_y, .s_shift_z,
        .m_valid, .m_ready, .m_cell_log_odds, .m_cell_stamp,
        .m_ring_x, .m_ring_y, .m_ring_z, .m_shift_result,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Random idle length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Present one input transfer and hold it until accepted. Valid stays high
    // into the next transfer when no gap follows.
    task automatic push_item(voxel_op_t op);
        int g;
        s_valid      <= 1'b1;
        s_action     <= op.act;
        s_cell_index <= op.idx;
        s_hit_count  <= op.cnt;
        s_stamp      <= op.stmp;
        s_shift_x    <= op.sx;
        s_shift_y    <= op.sy;
        s_shift_z    <= op.sz;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic write_reg(cfg_idx_t ri, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_all(logic [15:0] hw, logic [15:0] fw, logic [15:0] mx,
                             logic [15:0] mn, logic [15:0] ms);
        write_reg(CFG_HIT_WEIGHT, hw);
        write_reg(CFG_FREE_WEIGHT, fw);
        write_reg(CFG_LO_MAX, mx);
        write_reg(CFG_LO_MIN, mn);
        write_reg(CFG_MIN_SHIFT, ms);
    endtask

    // Drain all outstanding results, then give the back end time to settle.
    task automatic drain();
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic voxel_op_t mk(act_t a, logic [15:0] i, logic [7:0] c,
                                     logic [31:0] t, int x, int y, int z);
        voxel_op_t op;
        op.act = a; op.idx = i; op.cnt = c; op.stmp = t;
        op.sx = 8'(x); op.sy = 8'(y); op.sz = 8'(z);
        return op;
    endfunction

    function automatic logic signed [7:0] small_shift(int mag);
        int m;
        if ($urandom_range(1)) return 8'sd0;
        m = $urandom_range(1, mag);
        return $urandom_range(1) ? 8'(m) : 8'(-m);
    endfunction

    // Random item. Updates and reads aim mostly at a handful of hot cells so
    // that hits, frees, reads and slice clears meet on the same voxels.
    function automatic voxel_op_t rand_item();
        voxel_op_t op;
        int        p;
        op.act  = act_t'($urandom_range(3));
        op.idx  = ($urandom_range(99) < 80) ? hot_cells[$urandom_range(11)] : 16'($urandom);
        p = $urandom_range(99);
        op.cnt  = (p < 10) ? 8'd0 : (p < 20) ? 8'hff : (p < 70) ? 8'($urandom_range(1, 4))
                                                                : 8'($urandom);
        op.stmp = $urandom;
        op.sx = 8'($urandom); op.sy = 8'($urandom); op.sz = 8'($urandom);
        if (op.act == ACT_SHIFT) begin
            // Slides are costly in cycles: keep them small, clears rare.
            if ($urandom_range(3) != 0) op.act = act_t'($urandom_range(1) ? ACT_HIT : ACT_READ);
            else begin
                op.sx = small_shift(2);
                op.sy = small_shift(2);
                op.sz = small_shift(1);
                if (clears_left > 0 && $urandom_range(99) < 8) begin
                    clears_left--;
                    op.sx = $urandom_range(1) ? -8'sd128 : 8'($urandom_range(64, 127));
                end
            end
        end
        return op;
    endfunction

    // Stall the result channel at random; whole phases may run with no stall.
    initial begin
        int left;
        bit rdy;
        m_ready = 1'b0;
        left = 0; rdy = 1'b0;
        forever begin
            @(negedge aclk);
            if (left > 0) left--;
            else begin
                rdy  = no_idle || !rdy;
                left = rdy ? $urandom_range(1, 20) : gap_len();
            end
            m_ready <= rdy;
        end
    end

    // Sample all three channels at the rising edge; check results before
    // noting the input taken at the same edge.
    always @(posedge aclk) begin
        voxel_op_t  op;
        voxel_res_t r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                r.lo = m_cell_log_odds; r.st = m_cell_stamp;
                r.rx = m_ring_x; r.ry = m_ring_y; r.rz = m_ring_z;
                r.sr = m_shift_result;
                sb.check_result(r);
            end
            if (s_valid && s_ready) begin
                op = mk(act_t'(s_action), s_cell_index, s_hit_count, s_stamp,
                        s_shift_x, s_shift_y, s_shift_z);
                sb.note_input(op);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
                n_cfg++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        aresetn = 1'b0; s_valid = 1'b0; cfg_valid = 1'b0;
        s_action = '0; s_cell_index = '0; s_hit_count = '0; s_stamp = '0;
        s_shift_x = '0; s_shift_y = '0; s_shift_z = '0;
        cfg_index = '0; cfg_data = '0;
        quiet_cycles = 0; n_cfg = 0; no_idle = 1'b0;
        foreach (hot_cells[i]) hot_cells[i] = 16'($urandom);
        hot_cells[0] = 16'h0000;
        hot_cells[1] = 16'hffff;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under reset register values.
        push_item(mk(ACT_HIT,   16'h0000, 8'hff, 32'hffff_ffff, 0, 0, 0));
        push_item(mk(ACT_HIT,   16'h0000, 8'd1,  32'h0000_0000, 0, 0, 0));
        push_item(mk(ACT_FREE,  16'hffff, 8'hff, 32'h1234_5678, 0, 0, 0));
        push_item(mk(ACT_FREE,  16'hffff, 8'd0,  32'hdead_beef, 0, 0, 0));
        push_item(mk(ACT_HIT,   16'hffff, 8'd0,  32'hdead_beef, 0, 0, 0));
        push_item(mk(ACT_FREE,  16'h0000, 8'd2,  32'h0000_0001, 0, 0, 0));
        push_item(mk(ACT_READ,  16'h0000, 8'hff, 32'hffff_ffff, -1, -1, -1));
        push_item(mk(ACT_READ,  16'hffff, 8'd0,  32'h0, 0, 0, 0));
        push_item(mk(ACT_SHIFT, 16'h0000, 8'd0,  32'h0, 0, 0, 0));
        push_item(mk(ACT_SHIFT, 16'h0000, 8'd0,  32'h0, 2, -1, 1));
        push_item(mk(ACT_READ,  16'h0000, 8'd0,  32'h0, 0, 0, 0));
        push_item(mk(ACT_HIT,   16'h0410, 8'd3,  32'h0000_0abc, 0, 0, 0));
        push_item(mk(ACT_SHIFT, 16'h0410, 8'd0,  32'h0, -3, 0, -1));
        push_item(mk(ACT_HIT,   16'h8001, 8'd7,  32'h8000_0000, 0, 0, 0));
        push_item(mk(ACT_SHIFT, 16'h8001, 8'd0,  32'h0, 63, 0, 0));
        push_item(mk(ACT_HIT,   16'h8001, 8'd7,  32'h8000_0000, 0, 0, 0));
        push_item(mk(ACT_SHIFT, 16'h8001, 8'd0,  32'h0, 0, 0, -128));
        push_item(mk(ACT_READ,  16'h8001, 8'd0,  32'h0, 0, 0, 0));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                s_valid <= 1'b0;
                drain();
                case (ph)
                    1: write_all(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'd0);
                    2: write_all(16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'd127);
                    3: write_all(16'd5, 16'd300, 16'd1000, -16'sd1000, 16'd2);
                    default: write_all(16'($urandom_range(1, 2000)),
                                       16'(-$urandom_range(1, 2000)),
                                       16'($urandom_range(0, 3000)),
                                       16'(-$urandom_range(0, 3000)), 16'd1);
                endcase
            end
            no_idle = (ph == 1);
            for (int n = 0; n < PHASE_LEN; n++) push_item(rand_item());
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;
        drain();

        $display("Ran %0d input transfers and %0d results over %0d register writes",
                 sb.n_in, sb.n_out, n_cfg);
        $display("Shifts: %0d slides, %0d full clears, %0d ignored as small",
                 sb.n_slide, sb.n_clear, sb.n_small);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
